FILE: hw/rtl/fpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpc_pkg;

  localparam int CW     = 32;
  localparam int FRAC   = 16;
  localparam int HALF   = 32;
  localparam int CFG_DW = 64;
  localparam int CFG_IW = 3;
  localparam int NPLANE = 6;

  localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [HALF-1:0] half_t;
  typedef logic [NPLANE-1:0]      mask_t;

  localparam coord_t MAX_C = CW'(CMAX);
  localparam coord_t MIN_C = CW'(CMIN);

  localparam int PL_NEAR   = 0;
  localparam int PL_FAR    = 1;
  localparam int PL_RIGHT  = 2;
  localparam int PL_LEFT   = 3;
  localparam int PL_TOP    = 4;
  localparam int PL_BOTTOM = 5;

  typedef enum logic [CFG_IW-1:0] {
    REG_ORIGIN_XY   = 3'd0,
    REG_ORIGIN_Z    = 3'd1,
    REG_ROTATION_XY = 3'd2,
    REG_ROTATION_ZW = 3'd3,
    REG_SLOPES_RL   = 3'd4,
    REG_SLOPES_TB   = 3'd5,
    REG_NEAR        = 3'd6,
    REG_FAR         = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct packed {
    coord_t ox;
    coord_t oy;
    coord_t oz;
    coord_t qx;
    coord_t qy;
    coord_t qz;
    coord_t qw;
    coord_t sr;
    coord_t sl;
    coord_t st;
    coord_t sb;
    coord_t near_d;
    coord_t far_d;
  } cfg_t;

  function automatic coord_t clamp_h(half_t v);
    if (longint'(v) > CMAX) return MAX_C;
    if (longint'(v) < CMIN) return MIN_C;
    return CW'(v);
  endfunction

  function automatic coord_t sadd(coord_t a, coord_t b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] != s[CW-1]) return s[CW] ? MIN_C : MAX_C;
    return s[CW-1:0];
  endfunction

  function automatic coord_t ssub(coord_t a, coord_t b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} - {b[CW-1], b};
    if (s[CW] != s[CW-1]) return s[CW] ? MIN_C : MAX_C;
    return s[CW-1:0];
  endfunction

  function automatic coord_t smul(coord_t a, coord_t b);
    logic signed [2*CW-1:0] p;
    logic signed [2*CW-1:0] q;
    p = a * b;
    q = p >>> FRAC;
    if ((&q[2*CW-1:CW-1]) || !(|q[2*CW-1:CW-1])) return q[CW-1:0];
    return q[2*CW-1] ? MIN_C : MAX_C;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fpc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fpc_in_if
  import fpc_pkg::*;
();
  logic  valid;
  logic  ready;
  half_t point_x;
  half_t point_y;
  half_t point_z;

  modport source(output valid, output point_x, output point_y, output point_z, input ready);
  modport sink(input valid, input point_x, input point_y, input point_z, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/fpc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fpc_out_if
  import fpc_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  inside_res;
  mask_t outside_plane_mask;

  modport source(output valid, output inside_res, output outside_plane_mask, input ready);
  modport sink(input valid, input inside_res, input outside_plane_mask, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/frustum_point_containment.sv
// Frustum point containment.
// in_pt carries one point per item (point_x, point_y, point_z, signed Q16.16);
// out_res returns one item per point: outside_plane_mask (bit 0 near, 1 far,
// 2 right, 3 left, 4 top, 5 bottom) and inside_res, high when the mask is zero.
// Both channels move an item on a clock edge with valid and ready high.
// The cfg port writes one frustum register per cycle with cfg_we high; write
// only while no item is in flight.
// Pipeline: seven register stages (quaternion rotation in five stages, slope
// products and plane compares in two). Throughput: one item per cycle while
// out_res.ready stays high.
// Each stage holds its item while the next stage is full, so a stalled
// receiver fills the pipeline; in_pt.ready drops only once every stage
// holds an item. Nothing is dropped or repeated.
// Reset (synchronous, rst_n low) empties the pipeline and loads the frustum
// registers: identity rotation, everything else zero.
`timescale 1ns / 1ps
`default_nettype none

module frustum_point_containment
  import fpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  fpc_in_if.sink                 in_pt,
  fpc_out_if.source              out_res,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_idx,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t  cfg;
  logic  l_valid;
  logic  l_ready;
  vec3_t l_pt;

  fpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fpc_xform u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pt   (in_pt),
    .cfg     (cfg),
    .l_valid (l_valid),
    .l_ready (l_ready),
    .l_pt    (l_pt)
  );

  fpc_planes u_planes (
    .clk     (clk),
    .rst_n   (rst_n),
    .l_valid (l_valid),
    .l_ready (l_ready),
    .l_pt    (l_pt),
    .cfg     (cfg),
    .out_res (out_res)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/fpc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module fpc_cfg_regs
  import fpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_idx,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t                   cfg
);

  logic [CFG_DW-1:0] origin_xy_r;
  logic [HALF-1:0]   origin_z_r;
  logic [CFG_DW-1:0] rot_xy_r;
  logic [CFG_DW-1:0] rot_zw_r;
  logic [CFG_DW-1:0] slope_rl_r;
  logic [CFG_DW-1:0] slope_tb_r;
  logic [HALF-1:0]   near_r;
  logic [HALF-1:0]   far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_xy_r <= '0;
      origin_z_r  <= '0;
      rot_xy_r    <= '0;
      rot_zw_r    <= CFG_DW'(longint'(1) << FRAC);
      slope_rl_r  <= '0;
      slope_tb_r  <= '0;
      near_r      <= '0;
      far_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        REG_ORIGIN_XY:   origin_xy_r <= cfg_wdata;
        REG_ORIGIN_Z:    origin_z_r  <= cfg_wdata[HALF-1:0];
        REG_ROTATION_XY: rot_xy_r    <= cfg_wdata;
        REG_ROTATION_ZW: rot_zw_r    <= cfg_wdata;
        REG_SLOPES_RL:   slope_rl_r  <= cfg_wdata;
        REG_SLOPES_TB:   slope_tb_r  <= cfg_wdata;
        REG_NEAR:        near_r      <= cfg_wdata[HALF-1:0];
        REG_FAR:         far_r       <= cfg_wdata[HALF-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.ox     = clamp_h(origin_xy_r[2*HALF-1:HALF]);
    cfg.oy     = clamp_h(origin_xy_r[HALF-1:0]);
    cfg.oz     = clamp_h(origin_z_r);
    cfg.qx     = clamp_h(rot_xy_r[2*HALF-1:HALF]);
    cfg.qy     = clamp_h(rot_xy_r[HALF-1:0]);
    cfg.qz     = clamp_h(rot_zw_r[2*HALF-1:HALF]);
    cfg.qw     = clamp_h(rot_zw_r[HALF-1:0]);
    cfg.sr     = clamp_h(slope_rl_r[2*HALF-1:HALF]);
    cfg.sl     = clamp_h(slope_rl_r[HALF-1:0]);
    cfg.st     = clamp_h(slope_tb_r[2*HALF-1:HALF]);
    cfg.sb     = clamp_h(slope_tb_r[HALF-1:0]);
    cfg.near_d = clamp_h(near_r);
    cfg.far_d  = clamp_h(far_r);
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fpc_xform.sv
`timescale 1ns / 1ps
`default_nettype none

module fpc_xform
  import fpc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  fpc_in_if.sink     in_pt,
  input  wire cfg_t  cfg,
  output logic       l_valid,
  input  wire logic  l_ready,
  output vec3_t      l_pt
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  vec3_t  d1_r, d2_r, d3_r;
  coord_t sq_w_r, sq_x_r, sq_y_r, sq_z_r;
  vec3_t  pd2_r;
  coord_t cyz_r, czy_r, czx_r, cxz_r, cxy_r, cyx_r;
  coord_t s2_r, s3_r;
  coord_t t3_r, w2_3_r;
  vec3_t  c3_r;
  vec3_t  a4_r, b4_r, e4_r;
  vec3_t  l5_r;

  vec3_t  p_in;
  vec3_t  d1_nxt;
  coord_t s2_nxt;
  coord_t dot3;
  vec3_t  c3_nxt;
  vec3_t  l5_nxt;

  assign en5 = !v5_r || l_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_pt.ready = en1;
  assign l_valid     = v5_r;
  assign l_pt        = l5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_pt.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_comb begin
    p_in.x   = clamp_h(in_pt.point_x);
    p_in.y   = clamp_h(in_pt.point_y);
    p_in.z   = clamp_h(in_pt.point_z);
    d1_nxt.x = ssub(p_in.x, cfg.ox);
    d1_nxt.y = ssub(p_in.y, cfg.oy);
    d1_nxt.z = ssub(p_in.z, cfg.oz);
    s2_nxt   = ssub(sq_w_r, sadd(sadd(sq_x_r, sq_y_r), sq_z_r));
    dot3     = sadd(sadd(pd2_r.x, pd2_r.y), pd2_r.z);
    c3_nxt.x = ssub(cyz_r, czy_r);
    c3_nxt.y = ssub(czx_r, cxz_r);
    c3_nxt.z = ssub(cxy_r, cyx_r);
    l5_nxt.x = ssub(sadd(a4_r.x, b4_r.x), e4_r.x);
    l5_nxt.y = ssub(sadd(a4_r.y, b4_r.y), e4_r.y);
    l5_nxt.z = ssub(sadd(a4_r.z, b4_r.z), e4_r.z);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_r   <= d1_nxt;
      sq_w_r <= smul(cfg.qw, cfg.qw);
      sq_x_r <= smul(cfg.qx, cfg.qx);
      sq_y_r <= smul(cfg.qy, cfg.qy);
      sq_z_r <= smul(cfg.qz, cfg.qz);
    end
    if (en2) begin
      d2_r    <= d1_r;
      s2_r    <= s2_nxt;
      pd2_r.x <= smul(cfg.qx, d1_r.x);
      pd2_r.y <= smul(cfg.qy, d1_r.y);
      pd2_r.z <= smul(cfg.qz, d1_r.z);
      cyz_r   <= smul(cfg.qy, d1_r.z);
      czy_r   <= smul(cfg.qz, d1_r.y);
      czx_r   <= smul(cfg.qz, d1_r.x);
      cxz_r   <= smul(cfg.qx, d1_r.z);
      cxy_r   <= smul(cfg.qx, d1_r.y);
      cyx_r   <= smul(cfg.qy, d1_r.x);
    end
    if (en3) begin
      d3_r   <= d2_r;
      s3_r   <= s2_r;
      t3_r   <= sadd(dot3, dot3);
      c3_r   <= c3_nxt;
      w2_3_r <= sadd(cfg.qw, cfg.qw);
    end
    if (en4) begin
      a4_r.x <= smul(s3_r, d3_r.x);
      a4_r.y <= smul(s3_r, d3_r.y);
      a4_r.z <= smul(s3_r, d3_r.z);
      b4_r.x <= smul(t3_r, cfg.qx);
      b4_r.y <= smul(t3_r, cfg.qy);
      b4_r.z <= smul(t3_r, cfg.qz);
      e4_r.x <= smul(w2_3_r, c3_r.x);
      e4_r.y <= smul(w2_3_r, c3_r.y);
      e4_r.z <= smul(w2_3_r, c3_r.z);
    end
    if (en5) begin
      l5_r <= l5_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fpc_planes.sv
`timescale 1ns / 1ps
`default_nettype none

module fpc_planes
  import fpc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  l_valid,
  output logic       l_ready,
  input  wire vec3_t l_pt,
  input  wire cfg_t  cfg,
  fpc_out_if.source  out_res
);

  logic v6_r, v7_r;
  logic en6, en7;

  vec3_t  l6_r;
  coord_t mr_r, ml_r, mt_r, mb_r;
  mask_t  mask_r;

  coord_t plane_d [NPLANE];
  mask_t  mask_nxt;

  assign en7     = !v7_r || out_res.ready;
  assign en6     = !v6_r || en7;
  assign l_ready = en6;

  assign out_res.valid              = v7_r;
  assign out_res.outside_plane_mask = mask_r;
  assign out_res.inside_res         = !(|mask_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en6) v6_r <= l_valid;
      if (en7) v7_r <= v6_r;
    end
  end

  always_comb begin
    plane_d[PL_NEAR]   = ssub(cfg.near_d, l6_r.z);
    plane_d[PL_FAR]    = ssub(l6_r.z, cfg.far_d);
    plane_d[PL_RIGHT]  = ssub(l6_r.x, mr_r);
    plane_d[PL_LEFT]   = ssub(ml_r, l6_r.x);
    plane_d[PL_TOP]    = ssub(l6_r.y, mt_r);
    plane_d[PL_BOTTOM] = ssub(mb_r, l6_r.y);
    for (int i = 0; i < NPLANE; i++) begin
      mask_nxt[i] = !plane_d[i][CW-1] && (|plane_d[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      l6_r <= l_pt;
      mr_r <= smul(cfg.sr, l_pt.z);
      ml_r <= smul(cfg.sl, l_pt.z);
      mt_r <= smul(cfg.st, l_pt.z);
      mb_r <= smul(cfg.sb, l_pt.z);
    end
    if (en7) begin
      mask_r <= mask_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fpc_checker
  import fpc_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  in_valid,
  input wire logic  in_ready,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire logic  inside_res,
  input wire mask_t outside_plane_mask
);

  a_inside_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (inside_res == (outside_plane_mask == '0)))
    else $error("inside_res disagrees with outside_plane_mask");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled while the output side moves");

  a_empty_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result present right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(outside_plane_mask)))
    else $error("stalled result changed or vanished");

endmodule

bind frustum_point_containment fpc_checker u_fpc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_pt.valid),
  .in_ready           (in_pt.ready),
  .out_valid          (out_res.valid),
  .out_ready          (out_res.ready),
  .inside_res         (out_res.inside_res),
  .outside_plane_mask (out_res.outside_plane_mask)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import fpc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_LEN   = 24;
  localparam int DRAIN_AT     = 300;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_POINTS = 160;

  localparam int STYLE_PLAIN  = 0;
  localparam int STYLE_SKEWED = 1;
  localparam int STYLE_WILD   = 2;

  localparam coord_t Q_ONE     = 32'sd65536;
  localparam coord_t Q_NEG_ONE = -32'sd65536;
  localparam coord_t Q_ZERO    = 32'sd0;

  typedef struct packed {
    logic  is_inside;
    mask_t mask;
  } containment_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_wdata;

  fpc_in_if  in_if();
  fpc_out_if out_if();

  frustum_point_containment u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pt     (in_if),
    .out_res   (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  logic [CFG_DW-1:0] frustum_regs [8];
  vec3_t             point_q [$];
  containment_t      containment_q [$];
  containment_t      want;
  vec3_t             next_pt;

  int  idle_pct    = 0;
  int  gap_left    = 0;
  int  stall_left  = 0;
  int  sent_cnt    = 0;
  int  result_cnt  = 0;
  int  mismatches  = 0;
  int  cycle_cnt   = 0;
  bit  draining    = 1'b0;

  real ox_r, oy_r, oz_r, qx_r, qy_r, qz_r, qw_r;
  real near_r, far_r, rs_r, ls_r, ts_r, bs_r;

  always #2 clk = ~clk;

  function automatic longint sat_q(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function automatic longint add_q(longint a, longint b);
    return sat_q(a + b);
  endfunction

  function automatic longint sub_q(longint a, longint b);
    return sat_q(a - b);
  endfunction

  function automatic longint mul_q(longint a, longint b);
    return sat_q((a * b) >>> FRAC);
  endfunction

  function automatic longint lo_half(logic [CFG_DW-1:0] v);
    return $signed(v[31:0]);
  endfunction

  function automatic longint hi_half(logic [CFG_DW-1:0] v);
    return $signed(v[63:32]);
  endfunction

  function automatic containment_t classify_point(vec3_t p);
    longint dx, dy, dz, ux, uy, uz, qw, s, dot, t2, w2, cx, cy, cz, lx, ly, lz;
    longint plane_d [NPLANE];
    containment_t r;
    dx = sub_q(p.x, hi_half(frustum_regs[REG_ORIGIN_XY]));
    dy = sub_q(p.y, lo_half(frustum_regs[REG_ORIGIN_XY]));
    dz = sub_q(p.z, lo_half(frustum_regs[REG_ORIGIN_Z]));
    ux = hi_half(frustum_regs[REG_ROTATION_XY]);
    uy = lo_half(frustum_regs[REG_ROTATION_XY]);
    uz = hi_half(frustum_regs[REG_ROTATION_ZW]);
    qw = lo_half(frustum_regs[REG_ROTATION_ZW]);
    s   = sub_q(mul_q(qw, qw), add_q(add_q(mul_q(ux, ux), mul_q(uy, uy)), mul_q(uz, uz)));
    dot = add_q(add_q(mul_q(ux, dx), mul_q(uy, dy)), mul_q(uz, dz));
    t2  = add_q(dot, dot);
    w2  = add_q(qw, qw);
    cx  = sub_q(mul_q(uy, dz), mul_q(uz, dy));
    cy  = sub_q(mul_q(uz, dx), mul_q(ux, dz));
    cz  = sub_q(mul_q(ux, dy), mul_q(uy, dx));
    lx  = sub_q(add_q(mul_q(s, dx), mul_q(t2, ux)), mul_q(w2, cx));
    ly  = sub_q(add_q(mul_q(s, dy), mul_q(t2, uy)), mul_q(w2, cy));
    lz  = sub_q(add_q(mul_q(s, dz), mul_q(t2, uz)), mul_q(w2, cz));
    plane_d[PL_NEAR]   = sub_q(lo_half(frustum_regs[REG_NEAR]), lz);
    plane_d[PL_FAR]    = sub_q(lz, lo_half(frustum_regs[REG_FAR]));
    plane_d[PL_RIGHT]  = sub_q(lx, mul_q(hi_half(frustum_regs[REG_SLOPES_RL]), lz));
    plane_d[PL_LEFT]   = sub_q(mul_q(lo_half(frustum_regs[REG_SLOPES_RL]), lz), lx);
    plane_d[PL_TOP]    = sub_q(ly, mul_q(hi_half(frustum_regs[REG_SLOPES_TB]), lz));
    plane_d[PL_BOTTOM] = sub_q(mul_q(lo_half(frustum_regs[REG_SLOPES_TB]), lz), ly);
    for (int i = 0; i < NPLANE; i++) r.mask[i] = plane_d[i] > 0;
    r.is_inside = (r.mask == '0);
    return r;
  endfunction

  function automatic vec3_t mk_point(coord_t x, coord_t y, coord_t z);
    vec3_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  function automatic real rand_real(real lo, real hi);
    return lo + (hi - lo) * ($urandom_range(0, 1000000) / 1000000.0);
  endfunction

  function automatic coord_t to_q16(real v);
    return coord_t'($rtoi(v * 65536.0));
  endfunction

  // Except in the wild style, aim most points at the frustum in its local frame, then map them to world space.
  function automatic vec3_t gen_point(int style);
    real lz, lx, ly, s, dot, wx, wy, wz;
    int  pick;
    pick = $urandom_range(0, 99);
    if (style == STYLE_WILD || pick >= 80) begin
      if (pick < 90 && style == STYLE_WILD)
        return mk_point(coord_t'($urandom_range(0, 1 << 23)) - (32'sd1 << 22),
                        coord_t'($urandom_range(0, 1 << 23)) - (32'sd1 << 22),
                        coord_t'($urandom_range(0, 1 << 23)) - (32'sd1 << 22));
      return mk_point($urandom, $urandom, $urandom);
    end
    lz  = rand_real(near_r * 0.8, far_r * 1.2);
    lx  = rand_real(ls_r * 1.2, rs_r * 1.2) * lz;
    ly  = rand_real(bs_r * 1.2, ts_r * 1.2) * lz;
    s   = qw_r * qw_r - (qx_r * qx_r + qy_r * qy_r + qz_r * qz_r);
    dot = 2.0 * (qx_r * lx + qy_r * ly + qz_r * lz);
    wx  = s * lx + dot * qx_r + 2.0 * qw_r * (qy_r * lz - qz_r * ly);
    wy  = s * ly + dot * qy_r + 2.0 * qw_r * (qz_r * lx - qx_r * lz);
    wz  = s * lz + dot * qz_r + 2.0 * qw_r * (qx_r * ly - qy_r * lx);
    return mk_point(to_q16(ox_r + wx), to_q16(oy_r + wy), to_q16(oz_r + wz));
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp_v);
    $display("mismatch at result %0d: %s got %0d want %0d", result_cnt, what, got, exp_v);
    mismatches++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (point_q.size() != 0 || sent_cnt != result_cnt || containment_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic program_frustum();
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IW'(i);
      cfg_wdata <= frustum_regs[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_all(input logic [CFG_DW-1:0] v);
    for (int i = 0; i < 8; i++) frustum_regs[i] = v;
    program_frustum();
  endtask

  task automatic pick_frustum(input int style);
    real n, k;
    if (style == STYLE_WILD) begin
      for (int i = 0; i < 8; i++) frustum_regs[i] = {$urandom, $urandom};
    end else begin
      ox_r = rand_real(-16.0, 16.0);
      oy_r = rand_real(-16.0, 16.0);
      oz_r = rand_real(-16.0, 16.0);
      qx_r = rand_real(-1.0, 1.0);
      qy_r = rand_real(-1.0, 1.0);
      qz_r = rand_real(-1.0, 1.0);
      qw_r = rand_real(-1.0, 1.0);
      n = $sqrt(qx_r * qx_r + qy_r * qy_r + qz_r * qz_r + qw_r * qw_r);
      if (n < 0.1) begin
        qx_r = 0.0; qy_r = 0.0; qz_r = 0.0; qw_r = 1.0;
      end else begin
        qx_r = qx_r / n; qy_r = qy_r / n; qz_r = qz_r / n; qw_r = qw_r / n;
      end
      near_r = rand_real(0.1, 4.0);
      far_r  = near_r + rand_real(1.0, 64.0);
      rs_r   = rand_real(0.2, 2.0);
      ls_r   = -rand_real(0.2, 2.0);
      ts_r   = rand_real(0.2, 2.0);
      bs_r   = -rand_real(0.2, 2.0);
      k = (style == STYLE_SKEWED) ? rand_real(0.25, 3.0) : 1.0;
      frustum_regs[REG_ORIGIN_XY]   = {to_q16(ox_r), to_q16(oy_r)};
      frustum_regs[REG_ORIGIN_Z]    = {$urandom, to_q16(oz_r)};
      frustum_regs[REG_ROTATION_XY] = {to_q16(qx_r * k), to_q16(qy_r * k)};
      frustum_regs[REG_ROTATION_ZW] = {to_q16(qz_r * k), to_q16(qw_r * k)};
      frustum_regs[REG_SLOPES_RL]   = {to_q16(rs_r), to_q16(ls_r)};
      frustum_regs[REG_SLOPES_TB]   = {to_q16(ts_r), to_q16(bs_r)};
      frustum_regs[REG_NEAR]        = {$urandom, to_q16(near_r)};
      frustum_regs[REG_FAR]         = {$urandom, to_q16(far_r)};
    end
    program_frustum();
  endtask

  // Driver: advance to the next pending point once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
      draining = 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        containment_q.push_back(classify_point(mk_point(in_if.point_x, in_if.point_y,
                                                        in_if.point_z)));
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (draining) begin
          if (containment_q.size() == 0) draining = 1'b0;
          in_if.valid <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
          gap_left = $urandom_range(0, 2);
          in_if.valid <= 1'b0;
        end else if (point_q.size() != 0) begin
          next_pt = point_q.pop_front();
          in_if.valid   <= 1'b1;
          in_if.point_x <= next_pt.x;
          in_if.point_y <= next_pt.y;
          in_if.point_z <= next_pt.z;
          sent_cnt++;
          if (sent_cnt == DRAIN_AT || (idle_pct > 0 && $urandom_range(0, 299) == 0))
            draining = 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (containment_q.size() == 0) begin
          report_mismatch("result with no point pending", out_if.outside_plane_mask, 0);
        end else begin
          want = containment_q.pop_front();
          if (out_if.inside_res !== want.is_inside)
            report_mismatch("inside_res", out_if.inside_res, want.is_inside);
          if (out_if.outside_plane_mask !== want.mask)
            report_mismatch("outside_plane_mask", out_if.outside_plane_mask, want.mask);
        end
        result_cnt++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 2);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    int style;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.point_z = '0;
    out_if.ready  = 1'b0;
    for (int i = 0; i < 8; i++) frustum_regs[i] = '0;
    frustum_regs[REG_ROTATION_ZW] = {Q_ZERO, Q_ONE};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset frustum: identity rotation, every plane through the origin.
    idle_pct = 20;
    point_q.push_back(mk_point(Q_ZERO, Q_ZERO, Q_ZERO));
    point_q.push_back(mk_point(MAX_C, MAX_C, MAX_C));
    point_q.push_back(mk_point(MIN_C, MIN_C, MIN_C));
    point_q.push_back(mk_point(MAX_C, MIN_C, MAX_C));
    point_q.push_back(mk_point(MIN_C, MAX_C, MIN_C));
    point_q.push_back(mk_point(-32'sd1, -32'sd1, -32'sd1));
    point_q.push_back(mk_point(32'sd1, 32'sd1, 32'sd1));
    point_q.push_back(mk_point(Q_ZERO, Q_ZERO, Q_NEG_ONE));
    wait_drained();

    // Oversized quaternion and extreme planes drive the arithmetic into saturation.
    fill_all({MAX_C, MAX_C});
    point_q.push_back(mk_point(Q_ZERO, Q_ZERO, Q_ZERO));
    point_q.push_back(mk_point(MIN_C, MIN_C, MIN_C));
    point_q.push_back(mk_point(MAX_C, Q_ONE, MIN_C));
    wait_drained();

    fill_all({MIN_C, MIN_C});
    point_q.push_back(mk_point(Q_ZERO, Q_ZERO, Q_ZERO));
    point_q.push_back(mk_point(MAX_C, MAX_C, MAX_C));
    point_q.push_back(mk_point(Q_NEG_ONE, MIN_C, Q_ONE));
    wait_drained();

    // Clamped point-minus-origin must keep its sign.
    frustum_regs[REG_ORIGIN_XY]   = {MAX_C, MIN_C};
    frustum_regs[REG_ORIGIN_Z]    = {MIN_C, MAX_C};
    frustum_regs[REG_ROTATION_XY] = {Q_ZERO, Q_ZERO};
    frustum_regs[REG_ROTATION_ZW] = {Q_ZERO, Q_ONE};
    frustum_regs[REG_SLOPES_RL]   = {Q_ONE, Q_NEG_ONE};
    frustum_regs[REG_SLOPES_TB]   = {Q_ONE, Q_NEG_ONE};
    frustum_regs[REG_NEAR]        = {MAX_C, Q_ZERO};
    frustum_regs[REG_FAR]         = {Q_ZERO, MAX_C};
    program_frustum();
    point_q.push_back(mk_point(MIN_C, MAX_C, MIN_C));
    point_q.push_back(mk_point(MAX_C, MIN_C, MAX_C));
    point_q.push_back(mk_point(Q_ZERO, Q_ZERO, Q_ZERO));
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1)      style = STYLE_PLAIN;
      else if (ph % 5 == 4)          style = STYLE_WILD;
      else if (ph % 4 == 3)          style = STYLE_SKEWED;
      else                           style = STYLE_PLAIN;
      if (ph == NUM_PHASES - 1 || ph == 2) idle_pct = 0;
      else if (ph % 2 == 1)                idle_pct = 35;
      else                                 idle_pct = 12;
      pick_frustum(style);
      for (int i = 0; i < PHASE_POINTS; i++) point_q.push_back(gen_point(style));
      wait_drained();
    end

    repeat (SETTLE_LEN) @(posedge clk);
    if (containment_q.size() != 0)
      report_mismatch("results never returned", containment_q.size(), 0);
    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
